@@ src/bh_pkg.sv @@
// Shared types and constants for the byte histogram.
// No dependencies; imported by every module of the block but bh_ram.
`default_nettype none

package bh_pkg;

	// Fixed field widths and bin count
	localparam int unsigned BIN_W = 8;
	localparam int unsigned BINS  = 256;
	localparam int unsigned OUT_W = 32;

	// Request opcodes
	typedef enum logic {
		CMD_COUNT = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	// One decoded request as it sits in the front queue
	typedef struct packed {
		cmd_t             cmd;
		logic [BIN_W-1:0] bin;
	} req_t;

endpackage

`default_nettype wire

@@ src/bh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used by the back-end engine for the bin counters.
`default_nettype none

module bh_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ src/bh_front.sv @@
// Front end: accepts requests, decodes the opcode and buffers them in a
// four-entry queue for the back end. Depends on bh_pkg.
`default_nettype none

module bh_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     command,
	input  logic [bh_pkg::BIN_W-1:0] byte_value,
	output logic                     req_valid,
	output bh_pkg::req_t             req,
	input  logic                     req_pop
);
	import bh_pkg::*;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = 2;

	req_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;
	req_t             new_req;

	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign req_valid = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = req_pop && req_valid;
	assign req       = slot_q[rd_ptr_q];

	// Decode the incoming request
	always_comb begin
		new_req.cmd = cmd_t'(command);
		new_req.bin = byte_value;
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= new_req;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/bh_back.sv @@
// Back end: read-modify-write engine over the bin counter RAM, with one
// valid bit per bin so that untouched bins read as zero. Depends on bh_pkg, bh_ram.
`default_nettype none

module bh_back #(
	parameter int unsigned COUNTER_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  bh_pkg::req_t             req,
	output logic                     req_pop,
	output logic                     res_push,
	output logic [bh_pkg::OUT_W-1:0] res_data,
	input  logic                     res_full
);
	import bh_pkg::*;

	localparam int unsigned EXT_W = (COUNTER_WIDTH > OUT_W) ? COUNTER_WIDTH : OUT_W;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t                   state_q;
	logic [BINS-1:0]          valid_q;
	cmd_t                     cmd_s1;
	logic [BIN_W-1:0]         bin_s1;
	logic [COUNTER_WIDTH-1:0] rd_data;
	logic [COUNTER_WIDTH-1:0] cur;
	logic [COUNTER_WIDTH-1:0] next_cnt;
	logic [EXT_W-1:0]         cur_ext;
	logic                     wr_en;

	// Issue when a request waits; a read also needs room for its result
	assign req_pop = (state_q == ST_IDLE) && req_valid
		&& ((req.cmd == CMD_COUNT) || !res_full);

	// Execute state: counter value is back from the RAM
	assign cur      = valid_q[bin_s1] ? rd_data : '0;
	assign next_cnt = cur + COUNTER_WIDTH'(1);
	assign wr_en    = (state_q == ST_EXEC) && (cmd_s1 == CMD_COUNT);
	assign res_push = (state_q == ST_EXEC) && (cmd_s1 == CMD_READ);
	assign cur_ext  = EXT_W'(cur);
	assign res_data = cur_ext[OUT_W-1:0];

	bh_ram #(
		.WIDTH (COUNTER_WIDTH),
		.DEPTH (BINS)
	) u_cnt_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (bin_s1),
		.wr_data (next_cnt),
		.rd_en   (req_pop),
		.rd_addr (req.bin),
		.rd_data (rd_data)
	);

	// Sequencer and per-bin valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (wr_en) begin
						valid_q[bin_s1] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request held for the write-back cycle
	always_ff @(posedge clk) begin
		if (req_pop) begin
			cmd_s1 <= req.cmd;
			bin_s1 <= req.bin;
		end
	end

endmodule

`default_nettype wire

@@ src/bh_out.sv @@
// Result queue: two entries between the back end and the result port.
// Depends on bh_pkg.
`default_nettype none

module bh_out (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     res_push,
	input  logic [bh_pkg::OUT_W-1:0] res_data,
	output logic                     res_full,
	output logic                     empty,
	input  logic                     pop,
	output logic [bh_pkg::OUT_W-1:0] bin_count
);
	import bh_pkg::*;

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = 1;

	logic [OUT_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign res_full  = (count_q == (PTR_W+1)'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = res_push && !res_full;
	assign do_pop    = pop && !empty;
	assign bin_count = slot_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= res_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/byte_histogram.sv @@
// Byte histogram top level: front queue, counter engine, result queue.
// Depends on bh_pkg, bh_front, bh_back, bh_out.
//
// 256-bin byte frequency counter. A request with command 0 increments the
// counter of bin byte_value and returns nothing; command 1 returns the
// current count of bin byte_value (low 32 bits) on bin_count. All bins read
// zero after reset, with no clearing pass. Requests enter a four-deep queue.
// The counter engine does one request at a time, a read-modify-write on
// the counter RAM (registered read, then write-back), and takes no new
// request until it is done. From an empty block, while the engine keeps
// draining the queue, a burst of up to seven requests is taken back to back.
// Results wait in a two-deep queue, so a stalled reader does not stop the
// input until both queues fill. A read sees every count requested before it.
`default_nettype none

module byte_histogram #(
	parameter int unsigned COUNTER_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     command,
	input  logic [bh_pkg::BIN_W-1:0] byte_value,
	output logic                     empty,
	input  logic                     pop,
	output logic [bh_pkg::OUT_W-1:0] bin_count
);
	import bh_pkg::*;

	logic             req_valid;
	req_t             req;
	logic             req_pop;
	logic             res_push;
	logic [OUT_W-1:0] res_data;
	logic             res_full;

	bh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.byte_value (byte_value),
		.req_valid  (req_valid),
		.req        (req),
		.req_pop    (req_pop)
	);

	bh_back #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_full  (res_full)
	);

	bh_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_full  (res_full),
		.empty     (empty),
		.pop       (pop),
		.bin_count (bin_count)
	);

	// A result is never dropped at the result queue
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	// The engine only takes a request that is waiting
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |-> req_valid)
		else $error("engine popped an empty request queue");

	// A read result comes out in the cycle after its issue
	a_res_timing: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> $past(req_pop))
		else $error("result without an issue in the previous cycle");

	// Engine never takes requests on back-to-back cycles
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |=> !req_pop)
		else $error("engine issued on consecutive cycles");

endmodule

`default_nettype wire

@@ tb/tb_byte_histogram.sv @@
// Self-checking testbench for the byte histogram: directed table, then random requests.
// Depends on bh_pkg and byte_histogram; a local tally model predicts every read without a literal expectation.
`timescale 1ns / 1ps

module tb_byte_histogram;
	import bh_pkg::*;

	// Counters at their default width
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned RAND_ITEMS = 250;	// per idle phase
	localparam int unsigned MAX_SHOWN  = 10;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                push   = 1'b0;
	logic                pop    = 1'b0;
	logic                command    = 1'b0;
	logic [BIN_W-1:0]    byte_value = '0;
	logic                full;
	logic                empty;
	logic [OUT_W-1:0]    bin_count;

	// Local copy of the histogram and the reads still owed by the block
	logic [CNT_W-1:0]    bin_tally [BINS];
	logic [OUT_W-1:0]    pending_counts [$];
	logic [OUT_W-1:0]    want;
	int unsigned         mismatches   = 0;
	int unsigned         tx_idle_pct  = 0;
	int unsigned         rx_stall_pct = 0;
	logic [BIN_W-1:0]    hot_bin;

	// Directed request: literal expectation only where it is obvious
	typedef struct packed {
		cmd_t             cmd;
		logic [BIN_W-1:0] val;
		logic             lit_ok;
		logic [OUT_W-1:0] lit;
	} drill_t;

	drill_t drill [21] = '{
		'{CMD_READ,  8'h00, 1'b1, 32'd0},	// all bins clear after reset
		'{CMD_READ,  8'hFF, 1'b1, 32'd0},
		'{CMD_READ,  8'h55, 1'b1, 32'd0},
		'{CMD_COUNT, 8'h00, 1'b0, 32'd0},
		'{CMD_COUNT, 8'hFF, 1'b0, 32'd0},
		'{CMD_COUNT, 8'hFF, 1'b0, 32'd0},
		'{CMD_READ,  8'h00, 1'b1, 32'd1},
		'{CMD_READ,  8'hFF, 1'b1, 32'd2},
		'{CMD_COUNT, 8'hAA, 1'b0, 32'd0},
		'{CMD_READ,  8'hAA, 1'b0, 32'd0},	// read right behind its count
		'{CMD_COUNT, 8'h55, 1'b0, 32'd0},
		'{CMD_COUNT, 8'h55, 1'b0, 32'd0},
		'{CMD_COUNT, 8'h55, 1'b0, 32'd0},
		'{CMD_READ,  8'h55, 1'b0, 32'd0},
		'{CMD_COUNT, 8'h80, 1'b0, 32'd0},
		'{CMD_COUNT, 8'h7F, 1'b0, 32'd0},
		'{CMD_READ,  8'h80, 1'b0, 32'd0},
		'{CMD_READ,  8'h7F, 1'b0, 32'd0},
		'{CMD_COUNT, 8'h01, 1'b0, 32'd0},
		'{CMD_READ,  8'h01, 1'b0, 32'd0},
		'{CMD_READ,  8'hFE, 1'b1, 32'd0}
	};

	byte_histogram #(
		.COUNTER_WIDTH(CNT_W)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.byte_value(byte_value),
		.empty     (empty),
		.pop       (pop),
		.bin_count (bin_count)
	);

	// 4 ns clock
	initial begin
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic note_failure(input string what);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("[%0t] %s", $realtime, what);
	endtask

	// Apply one accepted request to the local histogram
	task automatic tally_request(input cmd_t c, input logic [BIN_W-1:0] b,
			output bit yields, output logic [OUT_W-1:0] cnt);
		yields = 1'b0;
		cnt    = '0;
		if (c == CMD_COUNT) begin
			bin_tally[b] = bin_tally[b] + 1'b1;	// wraps at counter width
		end else begin
			yields = 1'b1;
			cnt    = OUT_W'(bin_tally[b]);
		end
	endtask

	// Offer one request, with random gaps ahead of it, and wait until taken
	task automatic send_request(input cmd_t c, input logic [BIN_W-1:0] b,
			input logic lit_ok, input logic [OUT_W-1:0] lit);
		bit               yields;
		logic [OUT_W-1:0] cnt;
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push       <= 1'b1;
		command    <= c;
		byte_value <= b;
		do @(posedge clk); while (full !== 1'b0);
		tally_request(c, b, yields, cnt);
		if (yields)
			pending_counts.push_back(lit_ok ? lit : cnt);
	endtask

	// Random request: a hot bin takes many counts
	task automatic send_random();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			send_request(CMD_COUNT, hot_bin, 1'b0, '0);
		else if (r < 40)
			send_request(CMD_READ, hot_bin, 1'b0, '0);
		else if (r < 75)
			send_request(CMD_COUNT, BIN_W'($urandom_range(255)), 1'b0, '0);
		else
			send_request(CMD_READ, BIN_W'($urandom_range(255)), 1'b0, '0);
	endtask

	// Reader side: random stalls on pop
	always @(negedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Compare each popped result with the oldest pending read
	always @(posedge clk) begin
		if (arst_n && pop && empty === 1'b0) begin
			if (pending_counts.size() == 0) begin
				note_failure($sformatf("unexpected result bin_count=0x%08h", bin_count));
			end else begin
				want = pending_counts.pop_front();
				if (bin_count !== want)
					note_failure($sformatf("bin_count mismatch: expected 0x%08h, got 0x%08h",
						want, bin_count));
			end
		end
	end

	// Main sequence
	initial begin
		for (int i = 0; i < BINS; i++)
			bin_tally[i] = '0;
		hot_bin = BIN_W'($urandom_range(255));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests, back to back
		foreach (drill[i])
			send_request(drill[i].cmd, drill[i].val, drill[i].lit_ok, drill[i].lit);

		// Random requests under each idle pattern
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
				default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
			endcase
			repeat (RAND_ITEMS) send_random();
		end

		// Drain with the reader always ready
		@(negedge clk);
		push <= 1'b0;
		rx_stall_pct = 0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/bh_pkg.sv
src/bh_ram.sv
src/bh_front.sv
src/bh_back.sv
src/bh_out.sv
src/byte_histogram.sv
tb/tb_byte_histogram.sv
